/* rtl/core/tlf_pkg.sv */
package tlf_pkg;

  // Result word kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_LINE = 2'd1,
    KIND_PAGE = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  // Register indexes on the config port (byte address / 4)
  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_TAB_SPACING = 2'd1;
  localparam logic [1:0] REG_HIGH_PRINT = 2'd2;

  // Reset values
  localparam logic [7:0] LINE_WIDTH_RST = 8'd80;
  localparam logic [4:0] TAB_SPACING_RST = 5'd8;

  // Clamp limits
  localparam logic [7:0] LINE_WIDTH_MIN = 8'd4;
  localparam logic [4:0] TAB_SPACING_MAX = 5'd16;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_FFH   = 8'hFF;

  // Pending word list depth: full-line prefix (3) + main action (3)
  localparam int TOK_DEPTH = 6;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
  } token_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic token_t mk_char(input logic [7:0] c);
    token_t t;
    t.ch   = c;
    t.kind = KIND_CHAR;
    return t;
  endfunction

  function automatic token_t mk_ctrl(input kind_t k);
    token_t t;
    t.ch   = CH_NUL;
    t.kind = k;
    return t;
  endfunction

endpackage

/* rtl/core/text_line_formatter_core.sv */
// Sequence per byte: IDLE, then DIV for a tab (8 remainder steps), then LOAD and EMIT.
// A new byte is taken only in IDLE, after every result word of the last one has left;
//   the pace is set by the one-word output register and the shared bit-serial remainder unit.
// A newline/return swallowed after a formfeed gives no words.
// Reset (rst, synchronous, high): column 0, formfeed flag clear, output empty,
//   line_width 80, tab_spacing 8, high_bytes_printable 0.
module text_line_formatter_core import tlf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic [1:0]  out_kind,
  output logic        last_of_run
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [7:0] line_width;
  logic [4:0] tab_spacing;
  logic       high_bytes_printable;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width           <= LINE_WIDTH_RST;
      tab_spacing          <= TAB_SPACING_RST;
      high_bytes_printable <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LINE_WIDTH:  line_width           <= pwdata[7:0];
        REG_TAB_SPACING: tab_spacing          <= pwdata[4:0];
        REG_HIGH_PRINT:  high_bytes_printable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LINE_WIDTH:  prdata = {24'd0, line_width};
      REG_TAB_SPACING: prdata = {27'd0, tab_spacing};
      REG_HIGH_PRINT:  prdata = {31'd0, high_bytes_printable};
      default:         prdata = 32'd0;
    endcase
  end

  // Effective settings: width at least 4, spacing in 1..16
  logic [7:0] w_eff;
  logic [4:0] sp_eff;
  assign w_eff  = (line_width < LINE_WIDTH_MIN) ? LINE_WIDTH_MIN : line_width;
  assign sp_eff = (tab_spacing == 5'd0) ? 5'd1 :
                  (tab_spacing > TAB_SPACING_MAX) ? TAB_SPACING_MAX : tab_spacing;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t     state;
  logic [7:0] column;
  logic       skip_ff;     // drop a newline/return right after a formfeed
  logic [7:0] cur_byte;
  logic       wrapped;     // full-line prefix pending for this byte
  logic [4:0] rem;         // column mod spacing, built one bit a step
  logic [2:0] div_cnt;
  token_t     tok [TOK_DEPTH];
  logic [2:0] tok_cnt;
  logic [4:0] spc_cnt;     // trailing tab spaces

  logic in_acc, cur_nl, in_nl;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_nl    = (in_byte == CH_LF) || (in_byte == CH_CR);
  assign cur_nl   = (cur_byte == CH_LF) || (cur_byte == CH_CR);

  // Shared remainder step: restoring, one dividend bit per cycle
  logic [5:0] trial;
  logic [4:0] rem_step;
  assign trial    = {rem, column[div_cnt]};
  assign rem_step = (trial >= {1'b0, sp_eff}) ? 5'(trial - {1'b0, sp_eff}) : trial[4:0];

  // ---------------------------------------------------------------------------
  // Word list build for the current byte (used in ST_LOAD)
  // ---------------------------------------------------------------------------
  token_t     m [3];
  logic [1:0] m_cnt;
  logic [7:0] col_new;
  logic       skip_set;
  logic [4:0] spc_new;
  logic [8:0] c9, w9, target9;
  logic [7:0] caret_ch;
  logic       printable;
  token_t     load_tok [TOK_DEPTH];
  logic [2:0] load_cnt;

  assign c9       = {1'b0, column};
  assign w9       = {1'b0, w_eff};
  assign target9  = c9 + {4'd0, sp_eff} - {4'd0, rem};
  assign caret_ch = (cur_byte == CH_DEL) ? CH_QMARK : 8'({1'b0, cur_byte[6:0]} + CH_AT);
  assign printable = (cur_byte >= CH_SPACE && cur_byte <= CH_TILDE) ||
                     (high_bytes_printable && cur_byte >= CH_HIGH && cur_byte != CH_FFH);

  always_comb begin
    m[0]     = mk_ctrl(KIND_LINE);
    m[1]     = mk_ctrl(KIND_LINE);
    m[2]     = mk_ctrl(KIND_LINE);
    m_cnt    = 2'd0;
    col_new  = 8'd0;
    skip_set = 1'b0;
    spc_new  = 5'd0;
    if (wrapped && cur_nl) begin
      // swallowed by the full-line break
      m_cnt = 2'd0;
    end else if (cur_nl) begin
      m[0]  = mk_char(CH_CR);
      m[1]  = mk_char(CH_LF);
      m_cnt = 2'd3;
    end else if (cur_byte == CH_FF) begin
      m[0]     = mk_ctrl(KIND_PAGE);
      m_cnt    = 2'd1;
      skip_set = 1'b1;
    end else if (cur_byte == CH_NUL) begin
      m[0]  = mk_ctrl(KIND_END);
      m_cnt = 2'd1;
    end else if (cur_byte == CH_TAB) begin
      if (target9 >= w9) begin
        // stop at or past the line end: break instead
        if (high_bytes_printable) begin
          m_cnt = 2'd1;
        end else begin
          m[0]  = mk_char(CH_CR);
          m[1]  = mk_char(CH_LF);
          m_cnt = 2'd3;
        end
      end else begin
        spc_new = sp_eff - rem;
        col_new = target9[7:0];
      end
    end else if (printable) begin
      m[0]    = mk_char(cur_byte);
      m_cnt   = 2'd1;
      col_new = 8'(c9 + 9'd1);
    end else if (c9 + 9'd2 > w9) begin
      // caret pair does not fit: line end first
      m[1]    = mk_char(CH_CARET);
      m[2]    = mk_char(caret_ch);
      m_cnt   = 2'd3;
      col_new = 8'd2;
    end else begin
      m[0]    = mk_char(CH_CARET);
      m[1]    = mk_char(caret_ch);
      m_cnt   = 2'd2;
      col_new = 8'(c9 + 9'd2);
    end

    if (wrapped) begin
      load_tok[0] = mk_char(CH_LF);
      load_tok[1] = mk_char(CH_CR);
      load_tok[2] = mk_ctrl(KIND_LINE);
      load_tok[3] = m[0];
      load_tok[4] = m[1];
      load_tok[5] = m[2];
      load_cnt    = 3'd3 + {1'b0, m_cnt};
    end else begin
      load_tok[0] = m[0];
      load_tok[1] = m[1];
      load_tok[2] = m[2];
      load_tok[3] = m[2];
      load_tok[4] = m[2];
      load_tok[5] = m[2];
      load_cnt    = {1'b0, m_cnt};
    end
  end

  // ---------------------------------------------------------------------------
  // Output pop: one word per cycle whenever the output register is free
  // ---------------------------------------------------------------------------
  logic out_free, pop, pop_last;
  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_EMIT) && out_free;
  assign pop_last = (tok_cnt != 3'd0) ? (tok_cnt == 3'd1 && spc_cnt == 5'd0)
                                      : (spc_cnt == 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      column    <= 8'd0;
      skip_ff   <= 1'b0;
      tok_cnt   <= 3'd0;
      spc_cnt   <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      // word taken and no new one behind it
      if (out_valid && !out_stall && !pop) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cur_byte <= in_byte;
            skip_ff  <= 1'b0;
            rem      <= 5'd0;
            div_cnt  <= 3'd7;
            if (skip_ff && in_nl) begin
              state <= ST_IDLE;          // dropped after formfeed, no words
            end else begin
              wrapped <= (column >= w_eff);
              if (column >= w_eff) column <= 8'd0;
              state <= (in_byte == CH_TAB) ? ST_DIV : ST_LOAD;
            end
          end
        end
        ST_DIV: begin
          rem     <= rem_step;
          div_cnt <= div_cnt - 3'd1;
          if (div_cnt == 3'd0) state <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int i = 0; i < TOK_DEPTH; i++) tok[i] <= load_tok[i];
          tok_cnt <= load_cnt;
          spc_cnt <= spc_new;
          column  <= col_new;
          if (skip_set) skip_ff <= 1'b1;
          state <= ((load_cnt == 3'd0) && (spc_new == 5'd0)) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (pop) begin
            out_valid   <= 1'b1;
            last_of_run <= pop_last;
            if (tok_cnt != 3'd0) begin
              out_char <= (tok[0].kind == KIND_CHAR) ? tok[0].ch : CH_NUL;
              out_kind <= tok[0].kind;
              for (int i = 0; i < TOK_DEPTH - 1; i++) tok[i] <= tok[i + 1];
              tok_cnt <= tok_cnt - 3'd1;
            end else begin
              out_char <= CH_SPACE;
              out_kind <= KIND_CHAR;
              spc_cnt  <= spc_cnt - 5'd1;
            end
            if (pop_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The remainder stays below the spacing through every step
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < sp_eff))
    else $error("remainder out of range");

  // The emit phase always has at least one word left
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((tok_cnt != 3'd0) || (spc_cnt != 5'd0)))
    else $error("emit state with nothing pending");

  // Non-character words carry a zero byte
  a_ctrl_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_CHAR) |-> (out_char == CH_NUL))
    else $error("control word with nonzero char");

  // A fresh word is loaded only when the previous one left or the register was empty
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(last_of_run) && $stable(out_kind))
    else $error("stalled word overwritten");
`endif

endmodule
